// File: hw/rtl/dcrvat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcrvat_pkg;

   // Converter sample and derived widths.
   localparam int SAMPLE_BITS = 10;
   localparam int CENTRED_W   = SAMPLE_BITS + 1;

   // Exponential averages: x += v; x -= x >> EMA_SHIFT.
   localparam int EMA_SHIFT = 10;
   localparam int DC_W      = 21;
   localparam int NF_W      = 21;
   localparam logic [DC_W-1:0] DC_RESET = DC_W'(256 * 1024);
   localparam logic [NF_W-1:0] NF_RESET = NF_W'(3 * 1024);

   // Hysteresis dead zone and crossing counter.
   localparam int DZ_W = 11;
   localparam logic [DZ_W-1:0] DZ_MAX = '1;
   localparam int CNT_W = 8;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Configuration registers.
   localparam int ETHR_W     = 10;
   localparam int CTHR_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam logic [ETHR_W-1:0] ETHR_RESET = ETHR_W'(70);
   localparam logic [CTHR_W-1:0] CTHR_RESET = CTHR_W'(15);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENERGY_THR   = 1'b0,
      CSR_CROSSING_THR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ETHR_W-1:0] energy;
      logic [CTHR_W-1:0] crossing;
   } thresholds_type;

   // Stream payloads, first field in the highest bits.
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic [REQ_TDATA_W-SAMPLE_BITS-2:0] pad;
      logic                               rearm;
      logic [SAMPLE_BITS-1:0]             raw_sample;
   } req_beat_type;

   typedef struct packed {
      logic [CNT_W-1:0]            block_crossings;
      logic [SAMPLE_BITS-1:0]      block_energy;
      logic                        speech_start;
      logic [SAMPLE_BITS-1:0]      dc_bias;
      logic signed [CENTRED_W-1:0] centred_sample;
   } rsp_beat_type;

   // Between the DC tracker and the block analyzer.
   typedef struct packed {
      logic signed [CENTRED_W-1:0] centred;
      logic [SAMPLE_BITS-1:0]      bias;
      logic [SAMPLE_BITS-1:0]      magnitude;
      logic                        rearm;
   } front_beat_type;

endpackage

`default_nettype wire

// File: hw/rtl/dcrvat_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dcrvat_front import dcrvat_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] raw_sample,
   input  wire logic                   rearm,
   output logic                        beat_valid,
   output front_beat_type              beat,
   input  wire logic                   beat_ready
);

   logic                        valid_ff, valid_in;
   logic [DC_W-1:0]             dc_ff, dc_in;
   logic [DC_W-1:0]             dc_sum;
   front_beat_type              beat_ff, beat_in;
   logic                        accept;
   logic signed [CENTRED_W-1:0] centred;

   assign in_ready   = !valid_ff || beat_ready;
   assign accept     = in_valid && in_ready;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   // DC tracker and centering of the incoming sample.
   always_comb begin
      dc_sum  = dc_ff + DC_W'(raw_sample);
      dc_in   = dc_sum - (dc_sum >> EMA_SHIFT);
      beat_in.bias = dc_in[EMA_SHIFT +: SAMPLE_BITS];
      centred = $signed({1'b0, raw_sample}) - $signed({1'b0, beat_in.bias});
      beat_in.centred   = centred;
      beat_in.magnitude = centred[CENTRED_W-1] ? SAMPLE_BITS'(-centred)
                                               : SAMPLE_BITS'(centred);
      beat_in.rearm     = rearm;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (beat_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dc_ff    <= DC_RESET;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            dc_ff <= dc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/dcrvat_detect.sv
`timescale 1ns / 1ps
`default_nettype none

module dcrvat_detect import dcrvat_pkg::*; #(
   parameter int BLOCK_LEN = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   beat_valid,
   input  wire front_beat_type         beat,
   output logic                        beat_ready,
   input  wire thresholds_type         thresholds,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int POS_W  = $clog2(BLOCK_LEN);
   localparam int SUM_W  = SAMPLE_BITS + POS_W;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);
   localparam int CNT_LIMIT = (BLOCK_LEN < 255) ? BLOCK_LEN : 255;

   logic                   valid_ff, valid_in;
   rsp_beat_type           rsp_ff, rsp_in;
   logic                   last_ff, last_in;
   logic [NF_W-1:0]        nf_ff, nf_in;
   logic [DZ_W-1:0]        dz_ff, dz_in;
   logic [SUM_W-1:0]       esum_ff, esum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pol_ff, pol_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   armed_ff, armed_in;
   logic                   analyzed_ff, analyzed_in;

   logic                   take;
   logic                   first, last, block_open;
   logic [NF_W+1:0]        nf_x3;
   logic [NF_W+1-EMA_SHIFT:0] dz_raw;
   logic [DZ_W-1:0]        dz_start;
   logic [SUM_W-1:0]       esum_base, esum_acc;
   logic [CNT_W-1:0]       cnt_base;
   logic [NF_W-1:0]        nf_sum;
   logic signed [DZ_W+1:0] s_ext, dz_ext;
   logic [SAMPLE_BITS-1:0] avg;
   logic                   start_now;

   assign take       = beat_valid && beat_ready;
   assign beat_ready = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tlast  = last_ff;

   assign first      = (pos_ff == '0);
   assign last       = (pos_ff == POS_LAST);
   assign block_open = first && armed_ff;

   // Dead zone for a new block is taken from the floor before this sample.
   always_comb begin
      nf_x3  = {1'b0, nf_ff, 1'b0} + {2'b00, nf_ff};
      dz_raw = nf_x3[NF_W+1:EMA_SHIFT];
      dz_start = (dz_raw > {{(NF_W+2-EMA_SHIFT-DZ_W){1'b0}}, DZ_MAX})
                 ? DZ_MAX : dz_raw[DZ_W-1:0];
   end

   assign esum_base = block_open ? '0 : esum_ff;
   assign cnt_base  = block_open ? '0 : cnt_ff;
   assign esum_acc  = esum_base + SUM_W'(beat.magnitude);

   // Block average: a shift for a power-of-two length, otherwise an exact
   // reciprocal multiply (ceil(2^K / len) with K = SUM_W + POS_W).
   generate
      if ((BLOCK_LEN & (BLOCK_LEN - 1)) == 0) begin : g_avg_shift
         assign avg = esum_acc[POS_W +: SAMPLE_BITS];
      end else begin : g_avg_recip
         localparam int RECIP_K = SUM_W + POS_W;
         localparam int RECIP_W = SUM_W + 1;
         localparam logic [63:0] RECIP_FULL =
            ((64'd1 << RECIP_K) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN);
         localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
         logic [SUM_W+RECIP_W-1:0] product;
         assign product = (SUM_W + RECIP_W)'(esum_acc) * (SUM_W + RECIP_W)'(RECIP);
         assign avg     = product[RECIP_K +: SAMPLE_BITS];
      end
   endgenerate

   always_comb begin
      analyzed_in = first ? armed_ff : analyzed_ff;
      dz_in       = block_open ? dz_start : dz_ff;
      esum_in     = esum_base;
      cnt_in      = cnt_base;
      nf_in       = nf_ff;
      nf_sum      = nf_ff + NF_W'(beat.magnitude);
      pol_in      = pol_ff;
      armed_in    = armed_ff;
      pos_in      = last ? '0 : pos_ff + POS_W'(1);
      start_now   = 1'b0;
      last_in     = 1'b0;
      s_ext       = {{2{beat.centred[CENTRED_W-1]}}, beat.centred};
      dz_ext      = {2'b00, dz_in};

      if (analyzed_in) begin
         esum_in = esum_acc;
         nf_in   = nf_sum - (nf_sum >> EMA_SHIFT);
         priority if (s_ext > dz_ext && !pol_ff) begin
            pol_in = 1'b1;
            cnt_in = (cnt_base != CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
         end else if (s_ext < -dz_ext && pol_ff) begin
            pol_in = 1'b0;
            cnt_in = (cnt_base != CNT_MAX) ? cnt_base + CNT_W'(1) : cnt_base;
         end else begin
            pol_in = pol_ff;
         end
         if (last) begin
            last_in   = 1'b1;
            start_now = (avg > thresholds.energy) || (cnt_in > thresholds.crossing);
            if (start_now) begin
               armed_in = 1'b0;
               pol_in   = 1'b0;
            end
         end
      end else if (beat.rearm) begin
         armed_in = 1'b1;
         pol_in   = 1'b0;
      end

      rsp_in.centred_sample  = beat.centred;
      rsp_in.dc_bias         = beat.bias;
      rsp_in.speech_start    = start_now;
      rsp_in.block_energy    = last_in ? avg : '0;
      rsp_in.block_crossings = last_in ? cnt_in : '0;
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         nf_ff       <= NF_RESET;
         dz_ff       <= '0;
         esum_ff     <= '0;
         cnt_ff      <= '0;
         pol_ff      <= 1'b0;
         pos_ff      <= '0;
         armed_ff    <= 1'b1;
         analyzed_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            nf_ff       <= nf_in;
            dz_ff       <= dz_in;
            esum_ff     <= esum_in;
            cnt_ff      <= cnt_in;
            pol_ff      <= pol_in;
            pos_ff      <= pos_in;
            armed_ff    <= armed_in;
            analyzed_ff <= analyzed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff  <= rsp_in;
         last_ff <= last_in;
      end
   end

   a_stats_only_at_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> rsp_ff.block_energy == '0 && rsp_ff.block_crossings == '0)
      else $error("block statistics reported outside a block end");

   a_start_at_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.speech_start |-> last_ff)
      else $error("speech start without a block end");

   a_start_disarms: assert property (@(posedge clock) disable iff (reset)
      take && start_now |=> !armed_ff && !pol_ff)
      else $error("trigger did not disarm detection");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CNT_LIMIT))
      else $error("crossing count exceeds the block length");

endmodule

`default_nettype wire

// File: hw/rtl/dc_removal_voice_activity_trigger_core.sv
`timescale 1ns / 1ps
`default_nettype none

// DC removal and voice activity trigger.
// The req_ stream carries one converter sample per beat together with a rearm
// flag. Every accepted beat yields exactly one rsp_ beat: the sample with the
// running DC estimate removed, the estimate itself, and, on the last sample of
// an analyzed block (rsp_tlast high), the block average amplitude, the
// hysteretic zero crossing count and the speech start flag.
// A beat taken into the input register moves on to the result register, and
// so to the rsp_ port, once the result register is free. Throughput is one
// beat per cycle while the receiver keeps rsp_tready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; req_tready drops only when both are full.
// A synchronous reset restores the DC and noise-floor averages, aligns the
// block counter to the next sample, arms detection and loads the thresholds
// with 70 and 15. There is no clearing pass; the block is ready right away.
// The csr_ port writes a threshold at any edge with csr_we high; it should be
// written only while no beat is in flight.
module dc_removal_voice_activity_trigger_core import dcrvat_pkg::*; #(
   parameter int BLOCK_LEN = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // raw_sample [9:0], rearm [10], zero padding [15:11]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // centred_sample [10:0], dc_bias [20:11], speech_start [21],
   // block_energy [31:22], block_crossings [39:32]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   req_beat_type   req_beat;
   thresholds_type thr_ff, thr_in;
   logic           beat_valid, beat_ready;
   front_beat_type beat;

   assign req_beat = req_beat_type'(req_tdata);

   // Threshold registers; index decode covers both registers.
   always_comb begin
      thr_in = thr_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENERGY_THR:   thr_in.energy   = csr_wdata[ETHR_W-1:0];
            CSR_CROSSING_THR: thr_in.crossing = csr_wdata[CTHR_W-1:0];
            default:          thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.energy   <= ETHR_RESET;
         thr_ff.crossing <= CTHR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // Input register and DC tracker.
   dcrvat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .raw_sample (req_beat.raw_sample),
      .rearm      (req_beat.rearm),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   // Block energy, noise floor, crossings, trigger and result register.
   dcrvat_detect #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_detect (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready),
      .thresholds (thr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
